FILE: rtl/core/frequency_text_formatter_defines.svh
// assertion macros for the frequency text formatter checker
`ifndef FREQUENCY_TEXT_FORMATTER_DEFINES_SVH
`define FREQUENCY_TEXT_FORMATTER_DEFINES_SVH

// same-cycle implication on clk, idle in reset
`define FTF_ASSERT_SAME(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ftf check failed");

// next-cycle implication on clk, idle in reset
`define FTF_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ftf check failed");

`endif

FILE: rtl/core/ftf_pkg.sv
package ftf_pkg;

	localparam int BIN_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int CHAR_W     = 7;
	localparam int PC_W       = 5;
	localparam int PTR_W      = 4;
	localparam int CNT_W      = 5;

	typedef logic [PC_W-1:0]   pc_t;
	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_CONV_DONE,
		COND_SKIP_DONE,
		COND_PTR_LOW,
		COND_IS_KHZ
	} cond_t;

	typedef enum logic [1:0] {
		SRC_PTR,
		SRC_D2,
		SRC_D1,
		SRC_CONST
	} src_t;

	typedef struct packed {
		cond_t cond;
		pc_t   target;
		logic  stay;
		logic  dec_ptr;
		logic  emit;
		logic  load;
		logic  shift;
		src_t  src;
		char_t chr;
		logic  last;
	} ucode_t;

	typedef struct packed {
		logic  load;
		logic  shift;
		logic  dec_ptr;
		logic  emit;
		src_t  src;
		char_t chr;
		logic  last;
	} ctrl_t;

	typedef struct packed {
		logic conv_done;
		logic skip_done;
		logic ptr_low;
		logic is_khz;
		logic slot_free;
	} status_t;

	localparam pc_t PC_IDLE   = pc_t'(0);
	localparam pc_t PC_CONV   = pc_t'(1);
	localparam pc_t PC_SKIP   = pc_t'(2);
	localparam pc_t PC_DIGIT  = pc_t'(3);
	localparam pc_t PC_BRANCH = pc_t'(4);
	localparam pc_t PC_HZ     = pc_t'(5);
	localparam pc_t PC_KHZ    = pc_t'(10);

	localparam char_t CH_ZERO  = 7'h30;
	localparam char_t CH_DOT   = 7'h2E;
	localparam char_t CH_SPACE = 7'h20;
	localparam char_t CH_K     = 7'h6B;
	localparam char_t CH_H     = 7'h48;
	localparam char_t CH_Z     = 7'h7A;
	localparam char_t CH_NONE  = 7'h00;

	localparam logic [PTR_W-1:0] PTR_TOP    = PTR_W'(NUM_DIGITS - 1);
	localparam logic [PTR_W-1:0] PTR_KHZ_LO = PTR_W'(3);
	localparam logic [PTR_W-1:0] PTR_HZ_LO  = PTR_W'(0);
	localparam logic [CNT_W-1:0] CNT_TOP    = CNT_W'(BIN_W - 1);

endpackage

FILE: rtl/core/ftf_rom.sv
module ftf_rom
	import ftf_pkg::*;
(
	input  pc_t    pc,
	output ucode_t word
);

	function automatic ucode_t mk(cond_t c, pc_t tgt, logic st, logic dp, logic em,
			logic ld, logic sh, src_t s, char_t ch, logic ls);
		ucode_t w;
		w.cond    = c;
		w.target  = tgt;
		w.stay    = st;
		w.dec_ptr = dp;
		w.emit    = em;
		w.load    = ld;
		w.shift   = sh;
		w.src     = s;
		w.chr     = ch;
		w.last    = ls;
		return w;
	endfunction

	always_comb begin
		case (pc)
			PC_IDLE:   word = mk(COND_IN_VALID, PC_CONV, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
					SRC_CONST, CH_NONE, 1'b0);
			PC_CONV:   word = mk(COND_CONV_DONE, PC_SKIP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
					SRC_CONST, CH_NONE, 1'b0);
			PC_SKIP:   word = mk(COND_SKIP_DONE, PC_DIGIT, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
					SRC_CONST, CH_NONE, 1'b0);
			PC_DIGIT:  word = mk(COND_PTR_LOW, PC_BRANCH, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
					SRC_PTR, CH_NONE, 1'b0);
			PC_BRANCH: word = mk(COND_IS_KHZ, PC_KHZ, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
					SRC_CONST, CH_NONE, 1'b0);
			// hz suffix
			PC_HZ:     word = mk(COND_ALWAYS, PC_HZ + pc_t'(1), 1'b0, 1'b0, 1'b1, 1'b0,
					1'b0, SRC_CONST, CH_SPACE, 1'b0);
			PC_HZ + pc_t'(1): word = mk(COND_ALWAYS, PC_HZ + pc_t'(2), 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_CONST, CH_H, 1'b0);
			PC_HZ + pc_t'(2): word = mk(COND_ALWAYS, PC_HZ + pc_t'(3), 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_CONST, CH_Z, 1'b0);
			PC_HZ + pc_t'(3): word = mk(COND_ALWAYS, PC_HZ + pc_t'(4), 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_CONST, CH_SPACE, 1'b0);
			PC_HZ + pc_t'(4): word = mk(COND_ALWAYS, PC_IDLE, 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_CONST, CH_SPACE, 1'b1);
			// khz fraction and suffix
			PC_KHZ:    word = mk(COND_ALWAYS, PC_KHZ + pc_t'(1), 1'b0, 1'b0, 1'b1, 1'b0,
					1'b0, SRC_CONST, CH_DOT, 1'b0);
			PC_KHZ + pc_t'(1): word = mk(COND_ALWAYS, PC_KHZ + pc_t'(2), 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_D2, CH_NONE, 1'b0);
			PC_KHZ + pc_t'(2): word = mk(COND_ALWAYS, PC_KHZ + pc_t'(3), 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_D1, CH_NONE, 1'b0);
			PC_KHZ + pc_t'(3): word = mk(COND_ALWAYS, PC_KHZ + pc_t'(4), 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_CONST, CH_SPACE, 1'b0);
			PC_KHZ + pc_t'(4): word = mk(COND_ALWAYS, PC_KHZ + pc_t'(5), 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_CONST, CH_K, 1'b0);
			PC_KHZ + pc_t'(5): word = mk(COND_ALWAYS, PC_KHZ + pc_t'(6), 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_CONST, CH_H, 1'b0);
			PC_KHZ + pc_t'(6): word = mk(COND_ALWAYS, PC_IDLE, 1'b0, 1'b0, 1'b1,
					1'b0, 1'b0, SRC_CONST, CH_Z, 1'b1);
			default:   word = mk(COND_ALWAYS, PC_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
					SRC_CONST, CH_NONE, 1'b0);
		endcase
	end

endmodule

FILE: rtl/core/ftf_seq.sv
module ftf_seq
	import ftf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t status,
	output ctrl_t   ctrl,
	output logic    in_stall
);

	pc_t    pc_q;
	pc_t    pc_next;
	ucode_t word;
	logic   hold;
	logic   cond_true;

	ftf_rom u_rom (
		.pc   (pc_q),
		.word (word)
	);

	always_comb begin
		case (word.cond)
			COND_ALWAYS:    cond_true = 1'b1;
			COND_IN_VALID:  cond_true = in_valid;
			COND_CONV_DONE: cond_true = status.conv_done;
			COND_SKIP_DONE: cond_true = status.skip_done;
			COND_PTR_LOW:   cond_true = status.ptr_low;
			COND_IS_KHZ:    cond_true = status.is_khz;
			default:        cond_true = 1'b0;
		endcase
	end

	// an emitting step waits for a free output word
	assign hold = word.emit & ~status.slot_free;

	always_comb begin
		if (hold) begin
			pc_next = pc_q;
		end else if (cond_true) begin
			pc_next = word.target;
		end else if (word.stay) begin
			pc_next = pc_q;
		end else begin
			pc_next = pc_q + pc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_comb begin
		ctrl.load    = word.load & cond_true;
		ctrl.shift   = word.shift;
		ctrl.dec_ptr = word.dec_ptr & ~hold & ~cond_true;
		ctrl.emit    = word.emit & ~hold;
		ctrl.src     = word.src;
		ctrl.chr     = word.chr;
		ctrl.last    = word.last;
	end

	assign in_stall = (pc_q != PC_IDLE);

endmodule

FILE: rtl/core/ftf_dp.sv
module ftf_dp
	import ftf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_t            ctrl,
	input  logic [BIN_W-1:0] freq_hz,
	output status_t          status,
	output char_t            char_code,
	output logic             last_char,
	output logic             out_valid,
	input  logic             out_stall
);

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] bcd_adj;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_lo;
	logic [3:0]       digits [NUM_DIGITS];
	logic [3:0]       cur_digit;
	char_t            char_sel;
	logic             valid_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			digits[i] = bcd_q[4*i +: 4];
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= freq_hz;
			bcd_q <= '0;
			ptr_q <= PTR_TOP;
		end else begin
			if (ctrl.shift) begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
				bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			end
			if (ctrl.dec_ptr) begin
				ptr_q <= ptr_q - PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= CNT_TOP;
		end else if (ctrl.shift) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign status.is_khz    = |bcd_q[BCD_W-1:12];
	assign ptr_lo           = status.is_khz ? PTR_KHZ_LO : PTR_HZ_LO;
	assign cur_digit        = digits[ptr_q];
	assign status.conv_done = (cnt_q == '0);
	assign status.ptr_low   = (ptr_q == ptr_lo);
	assign status.skip_done = (cur_digit != 4'd0) | status.ptr_low;
	assign status.slot_free = ~valid_q | ~out_stall;

	always_comb begin
		case (ctrl.src)
			SRC_PTR:   char_sel = CH_ZERO + {3'b000, cur_digit};
			SRC_D2:    char_sel = CH_ZERO + {3'b000, digits[2]};
			SRC_D1:    char_sel = CH_ZERO + {3'b000, digits[1]};
			SRC_CONST: char_sel = ctrl.chr;
			default:   char_sel = ctrl.chr;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			char_code <= char_sel;
			last_char <= ctrl.last;
		end
	end

	assign out_valid = valid_q;

endmodule

FILE: rtl/core/frequency_text_formatter.sv
// a 32-bit word is converted to bcd bit-serially, and leading zero digits are skipped,
// then the digits and the suffix are emitted one character per emitting step
// a new frequency is accepted only once the last character of the text is emitted
// output stalls hold the sequencer on the emitting step
// reset returns the step counter to idle and clears the output valid
module frequency_text_formatter
	import ftf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [BIN_W-1:0] freq_hz,
	input  logic             in_valid,
	output logic             in_stall,
	output char_t            char_code,
	output logic             last_char,
	output logic             out_valid,
	input  logic             out_stall
);

	ctrl_t   ctrl;
	status_t status;

	ftf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.ctrl     (ctrl),
		.in_stall (in_stall)
	);

	ftf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.freq_hz   (freq_hz),
		.status    (status),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule

FILE: rtl/core/ftf_checker.sv
`include "frequency_text_formatter_defines.svh"

module ftf_checker
	import ftf_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_stall,
	input char_t char_code,
	input logic  last_char,
	input logic  out_valid,
	input logic  out_stall
);

	// stalled output word holds
	`FTF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_code) && $stable(last_char))

	// one frequency at a time
	`FTF_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

	// a new frequency starts only after the previous text has reached its last character
	`FTF_ASSERT_NEXT(a_text_done, in_valid && !in_stall, !out_valid || last_char)

	// no text is emitted while waiting for input beyond a held last character
	`FTF_ASSERT_SAME(a_idle_quiet, !in_stall && out_valid, last_char)

endmodule

bind frequency_text_formatter ftf_checker u_ftf_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ftf_pkg::*;

	localparam int STUCK_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 100;
	localparam int CALM_ITEMS = 20;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		char_t code;
		logic  last;
	} char_word_t;

	typedef struct {
		logic [BIN_W-1:0] freq;
		string            text;
	} freq_row_t;

	logic             clk;
	logic             arst_n;
	logic [BIN_W-1:0] freq_hz;
	logic             in_valid;
	logic             in_stall;
	char_t            char_code;
	logic             last_char;
	logic             out_valid;
	logic             out_stall;

	char_word_t pending_chars[$];
	freq_row_t  freq_rows[$];
	int         mismatches;
	int         stuck_cycles;
	logic       calm;

	frequency_text_formatter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.freq_hz   (freq_hz),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	always #6 clk = ~clk;

	// text of one frequency, pushed as expected characters
	function automatic void predict_text(input logic [BIN_W-1:0] f);
		logic [BIN_W-1:0] value;
		logic [BIN_W-1:0] frac;
		char_t            text[$];
		char_t            digits[$];
		value = (f >= 1000) ? f / 1000 : f;
		if (value == 0) begin
			digits.push_front(CH_ZERO);
		end
		while (value != 0) begin
			digits.push_front(char_t'(CH_ZERO + value % 10));
			value = value / 10;
		end
		text = digits;
		if (f >= 1000) begin
			frac = (f % 1000) / 10;
			text.push_back(CH_DOT);
			text.push_back(char_t'(CH_ZERO + frac / 10));
			text.push_back(char_t'(CH_ZERO + frac % 10));
			text.push_back(CH_SPACE);
			text.push_back(CH_K);
			text.push_back(CH_H);
			text.push_back(CH_Z);
		end else begin
			text.push_back(CH_SPACE);
			text.push_back(CH_H);
			text.push_back(CH_Z);
			text.push_back(CH_SPACE);
			text.push_back(CH_SPACE);
		end
		foreach (text[i]) begin
			pending_chars.push_back('{text[i], logic'(i == text.size() - 1)});
		end
	endfunction

	// drive one word and wait for it to be taken; called at a falling edge
	task automatic send_freq(input logic [BIN_W-1:0] f, input string text);
		if (!calm && $urandom_range(0, 2) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid = 1'b1;
		freq_hz = f;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (text.len() == 0) begin
			predict_text(f);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				pending_chars.push_back('{char_t'(text[i]), logic'(i == text.len() - 1)});
			end
		end
		@(negedge clk);
	endtask

	// output side back-pressure
	initial begin
		out_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, 40)) @(negedge clk);
			if (!calm) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		char_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected char %h last %b", char_code, last_char);
				end
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want.code || last_char !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("char mismatch: expected %h last %b, got %h last %b",
							want.code, want.last, char_code, last_char);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [BIN_W-1:0] f;
		logic [BIN_W-1:0] decade;
		clk = 1'b0;
		arst_n = 1'b0;
		freq_hz = '0;
		in_valid = 1'b0;
		calm = 1'b0;
		mismatches = 0;
		stuck_cycles = 0;

		freq_rows.push_back('{32'd0, "0 Hz  "});
		freq_rows.push_back('{32'd5, "5 Hz  "});
		freq_rows.push_back('{32'd9, ""});
		freq_rows.push_back('{32'd10, ""});
		freq_rows.push_back('{32'd99, ""});
		freq_rows.push_back('{32'd100, ""});
		freq_rows.push_back('{32'd999, "999 Hz  "});
		freq_rows.push_back('{32'd1000, "1.00 kHz"});
		freq_rows.push_back('{32'd1009, "1.00 kHz"});
		freq_rows.push_back('{32'd1010, "1.01 kHz"});
		freq_rows.push_back('{32'd1999, "1.99 kHz"});
		freq_rows.push_back('{32'd9999, ""});
		freq_rows.push_back('{32'd10000, ""});
		freq_rows.push_back('{32'd123456, ""});
		freq_rows.push_back('{32'd999999, ""});
		freq_rows.push_back('{32'd1000000, ""});
		freq_rows.push_back('{32'd1000000000, ""});
		freq_rows.push_back('{32'h8000_0000, ""});
		freq_rows.push_back('{32'h5555_5555, ""});
		freq_rows.push_back('{32'hAAAA_AAAA, ""});
		freq_rows.push_back('{32'hFFFF_FFFF, "4294967.29 kHz"});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		foreach (freq_rows[i]) begin
			send_freq(freq_rows[i].freq, freq_rows[i].text);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			case ($urandom_range(0, 4))
				0: f = $urandom_range(0, 999);
				1: begin
					decade = 1000;
					repeat ($urandom_range(0, 6)) decade = decade * 10;
					f = decade + $urandom_range(0, 20) - 10;
				end
				2: f = $urandom;
				3: f = $urandom >> $urandom_range(0, 31);
				default: f = $urandom_range(1000, 99999);
			endcase
			send_freq(f, "");
		end
		in_valid = 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
